FILE: src/necir_pkg.sv
// Shared types and constants for the NEC infrared pulse decoder.
// No dependencies; the top level, the classifier and the frame file refer to this package by scoped names.

package necir_pkg;

    // Field widths
    localparam int unsigned PulseWidth   = 16;
    localparam int unsigned CommandWidth = 8;
    localparam int unsigned FrameBits    = 32;
    localparam int unsigned CountWidth   = 6;
    localparam int unsigned CommandLsb   = 16;

    // Pulse width limits in microseconds (lower bound of the next class)
    localparam logic [PulseWidth-1:0] LimMin    = 16'd250;
    localparam logic [PulseWidth-1:0] LimShort  = 16'd1200;
    localparam logic [PulseWidth-1:0] LimLong   = 16'd2000;
    localparam logic [PulseWidth-1:0] LimRepeat = 16'd3000;
    localparam logic [PulseWidth-1:0] LimHeader = 16'd6000;
    localparam logic [PulseWidth-1:0] LimLeader = 16'd12000;

    // Full frame count
    localparam logic [CountWidth-1:0] CountFull = 6'd32;

    // Word kinds carried in tuser
    localparam logic ActionPulse = 1'b0;
    localparam logic ActionRead  = 1'b1;

    // Pulse class
    typedef enum logic [2:0] {
        PC_ERROR  = 3'd0,
        PC_SHORT  = 3'd1,
        PC_LONG   = 3'd2,
        PC_REPEAT = 3'd3,
        PC_HEADER = 3'd4,
        PC_LEADER = 3'd5
    } pulse_class_t;

    // Result word
    typedef struct packed {
        logic                    code_ready;
        logic [CommandWidth-1:0] command_byte;
    } result_t;

endpackage

FILE: src/nec_ir_pulse_decoder_unit.sv
// NEC infrared pulse decoder, top level: input register, classifier, frame state, result register.
// A word moves from the input register into the result register, which drives m_tvalid.
// Throughput: one word per cycle while m_tready keeps up; the two registers each hold one
// word, so a new word is taken while a finished result waits on m_tready.
// Reset: rst_n low clears the frame, the bit count and both valid flags at once.
// Depends on necir_pkg, necir_classify and necir_frame.

module nec_ir_pulse_decoder_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [15:0] pulse_time
    input  logic [0:0]                          s_tuser,   // [0] action
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] command_byte
    output logic [0:0]                          m_tuser    // [0] code_ready
);

    logic                              in_valid_reg;
    logic                              in_action_reg;
    logic [necir_pkg::PulseWidth-1:0]  in_time_reg;
    logic                              out_valid_reg;
    necir_pkg::result_t                out_reg;
    logic                              advance;
    necir_pkg::pulse_class_t           pulse_class;
    necir_pkg::result_t                result;

    // Move the held word on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_action_reg <= s_tuser[0];
            in_time_reg   <= s_tdata;
        end
    end

    necir_classify u_classify
    (
        .pulse_time  (in_time_reg),
        .pulse_class (pulse_class)
    );

    necir_frame u_frame
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .action      (in_action_reg),
        .pulse_class (pulse_class),
        .result      (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.command_byte;
    assign m_tuser[0] = out_reg.code_ready;

endmodule

FILE: src/necir_classify.sv
// Pulse width classifier: sorts a measured width into one of the NEC pulse classes.
// Depends on necir_pkg.

module necir_classify
(
    input  logic [necir_pkg::PulseWidth-1:0] pulse_time,
    output necir_pkg::pulse_class_t          pulse_class
);

    // Compare against the fixed limits, lowest first
    always_comb
    begin
        if (pulse_time < necir_pkg::LimMin)
        begin
            pulse_class = necir_pkg::PC_ERROR;
        end
        else if (pulse_time < necir_pkg::LimShort)
        begin
            pulse_class = necir_pkg::PC_SHORT;
        end
        else if (pulse_time < necir_pkg::LimLong)
        begin
            pulse_class = necir_pkg::PC_LONG;
        end
        else if (pulse_time < necir_pkg::LimRepeat)
        begin
            pulse_class = necir_pkg::PC_REPEAT;
        end
        else if (pulse_time < necir_pkg::LimHeader)
        begin
            pulse_class = necir_pkg::PC_HEADER;
        end
        else if (pulse_time < necir_pkg::LimLeader)
        begin
            pulse_class = necir_pkg::PC_LEADER;
        end
        else
        begin
            pulse_class = necir_pkg::PC_ERROR;
        end
    end

endmodule

FILE: src/necir_frame.sv
// Frame assembly: holds the received bits and the bit count, and forms the result word.
// Depends on necir_pkg.

module necir_frame
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    action,
    input  necir_pkg::pulse_class_t pulse_class,
    output necir_pkg::result_t      result
);

    logic [necir_pkg::FrameBits-1:0]  frame_reg;
    logic [necir_pkg::FrameBits-1:0]  frame_next;
    logic [necir_pkg::CountWidth-1:0] count_reg;
    logic [necir_pkg::CountWidth-1:0] count_next;
    logic                             frame_full;

    // Count never exceeds a full frame, so the top bit marks it
    assign frame_full = (count_reg == necir_pkg::CountFull);

    // Work out the next state and the result for the word in hand
    always_comb
    begin
        frame_next          = frame_reg;
        count_next          = count_reg;
        result.code_ready   = 1'b0;
        result.command_byte = '0;
        if (action == necir_pkg::ActionRead)
        begin
            if (frame_full)
            begin
                result.code_ready   = 1'b1;
                result.command_byte = frame_reg[necir_pkg::CommandLsb +: necir_pkg::CommandWidth];
                count_next          = '0;
            end
        end
        else if (!count_reg[necir_pkg::CountWidth-1])
        begin
            case (pulse_class)
                necir_pkg::PC_SHORT:
                begin
                    frame_next = {1'b0, frame_reg[necir_pkg::FrameBits-1:1]};
                    count_next = count_reg + 1'b1;
                end
                necir_pkg::PC_LONG:
                begin
                    frame_next = {1'b1, frame_reg[necir_pkg::FrameBits-1:1]};
                    count_next = count_reg + 1'b1;
                end
                necir_pkg::PC_HEADER:
                begin
                    frame_next = '0;
                    count_next = '0;
                end
                necir_pkg::PC_REPEAT:
                begin
                    if (count_reg == '0)
                    begin
                        count_next = necir_pkg::CountFull;
                    end
                end
                default:
                begin
                    count_next = '0;
                end
            endcase
        end
    end

    // Commit the state when the word moves on to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            frame_reg <= frame_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: src/necir_checker.sv
// Port-level checks for the NEC infrared pulse decoder, attached to the top level by bind.
// Depends on nec_ir_pulse_decoder_unit.

module necir_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [0:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser
);

    // Hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // An empty result register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // A result without a ready code carries a zero command
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("command byte set on a not-ready result");

    // A pulse word reaches the output as a not-ready zero result if nothing is queued ahead
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] ##1 !m_tvalid
        |=> m_tvalid && !m_tuser[0] && m_tdata == 8'd0)
        else $error("pulse word gave a wrong or late result");

endmodule

bind nec_ir_pulse_decoder_unit necir_checker u_necir_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
